[sv/lcd_pixel_unpack_convert_unit_assert.svh]
// Assertion macros shared by the pixel unpacker modules.
// Both expect clk and rst_n in scope; each use ends its own statement.
`ifndef LCD_PIXEL_UNPACK_CONVERT_UNIT_ASSERT_SVH
`define LCD_PIXEL_UNPACK_CONVERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LPUC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPUC_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPUC_ASSERT(label, prop, msg)
`define LPUC_NEVER(label, cond, msg)
`endif
`endif

[sv/lpuc_pkg.sv]
package lpuc_pkg;

    localparam int PALETTE_DEPTH  = 256;
    localparam int PAL_IDX_W      = 8;
    localparam int COUNT_BITS_DEF = 20;
    localparam int FRAME_W        = 20;
    localparam int EMIT_W         = 6;     // up to 32 pixels per word
    localparam int WORK_DEPTH     = 2;
    localparam int RES_DEPTH      = 4;
    localparam int RES_LVL_W      = $clog2(RES_DEPTH + 1);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RGB_ORDER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_ENDIAN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ENDIAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 3'd4;

    // pixel modes
    localparam logic [2:0] MODE_PAL1 = 3'd0;
    localparam logic [2:0] MODE_PAL2 = 3'd1;
    localparam logic [2:0] MODE_PAL4 = 3'd2;
    localparam logic [2:0] MODE_PAL8 = 3'd3;
    localparam logic [2:0] MODE_1555 = 3'd4;
    localparam logic [2:0] MODE_888  = 3'd5;
    localparam logic [2:0] MODE_565  = 3'd6;
    localparam logic [2:0] MODE_444  = 3'd7;

    typedef struct packed {
        logic [2:0]         pixel_mode;
        logic               rgb_order;
        logic               byte_endian;
        logic               pixel_endian;
        logic [FRAME_W-1:0] frame_pixels;
    } cfg_t;

    typedef struct packed {
        logic        func;
        logic [31:0] data_word;
        logic [7:0]  palette_index;
        logic        frame_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] middle_byte;
        logic [7:0] third_byte;
        logic       last_of_word;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                 pal_write;
        logic [31:0]          word;
        logic [PAL_IDX_W-1:0] pidx;
        logic [EMIT_W-1:0]    n_emit;
    } work_t;

endpackage

[sv/lpuc_fifo.sv]
module lpuc_fifo #(
    parameter int WIDTH = $bits(lpuc_pkg::out_item_t),
    parameter int DEPTH = lpuc_pkg::RES_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push, do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign level   = level_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   level_next = level_reg + 1'b1;
            2'b01:   level_next = level_reg - 1'b1;
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/lpuc_front.sv]
module lpuc_front #(
    parameter int COUNT_BITS = lpuc_pkg::COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lpuc_pkg::in_item_t in_item,
    input  lpuc_pkg::cfg_t    cfg,
    input  logic              wq_full,
    output logic              wq_push,
    output lpuc_pkg::work_t   wq_data
);

    localparam int CMP_W = (COUNT_BITS > lpuc_pkg::FRAME_W) ? COUNT_BITS : lpuc_pkg::FRAME_W;
    localparam int EW    = lpuc_pkg::EMIT_W;

    logic [COUNT_BITS-1:0] count_reg, count_next, count_base;
    logic [CMP_W-1:0]      base_ext, fp_ext, cmax_ext, lim, avail;
    logic [EW-1:0]         n_pix, n_emit;
    logic                  accept;

    assign accept = push && !wq_full;

    // pixels a word yields in the current mode
    always_comb
    begin
        case (cfg.pixel_mode)
            lpuc_pkg::MODE_PAL1: n_pix = EW'(32);
            lpuc_pkg::MODE_PAL2: n_pix = EW'(16);
            lpuc_pkg::MODE_PAL4: n_pix = EW'(8);
            lpuc_pkg::MODE_PAL8: n_pix = EW'(4);
            lpuc_pkg::MODE_888:  n_pix = EW'(1);
            default:             n_pix = EW'(2);
        endcase
    end

    // room left in the frame, capped by the counter ceiling
    always_comb
    begin
        count_base = in_item.frame_start ? '0 : count_reg;
        base_ext   = CMP_W'(count_base);
        fp_ext     = CMP_W'(cfg.frame_pixels);
        cmax_ext   = CMP_W'({COUNT_BITS{1'b1}});
        lim        = (fp_ext < cmax_ext) ? fp_ext : cmax_ext;
        avail      = (base_ext >= lim) ? '0 : lim - base_ext;
        n_emit     = (avail < CMP_W'(n_pix)) ? avail[EW-1:0] : n_pix;
        count_next = count_reg;
        if (accept)
        begin
            count_next = in_item.func ? count_base : count_base + COUNT_BITS'(n_emit);
        end
    end

    // words that yield nothing are dropped here
    assign wq_push           = accept && (in_item.func || (n_emit != '0));
    assign wq_data.pal_write = in_item.func;
    assign wq_data.word      = in_item.data_word;
    assign wq_data.pidx      = in_item.palette_index;
    assign wq_data.n_emit    = n_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[sv/lpuc_back.sv]
`include "lcd_pixel_unpack_convert_unit_assert.svh"

module lpuc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lpuc_pkg::cfg_t                     cfg,
    input  logic                               wq_empty,
    input  lpuc_pkg::work_t                    head,
    output logic                               wq_pop,
    input  logic [lpuc_pkg::RES_LVL_W-1:0]     res_level,
    output logic                               res_push,
    output lpuc_pkg::out_item_t                res_data
);

    localparam int IW = lpuc_pkg::PAL_IDX_W;
    localparam int EW = lpuc_pkg::EMIT_W;
    localparam int JW = EW - 1;

    // palette: 1555 entries, valid bits make unwritten entries read as zero
    logic [15:0]                       pal_mem [lpuc_pkg::PALETTE_DEPTH];
    logic [lpuc_pkg::PALETTE_DEPTH-1:0] pal_valid_reg, pal_valid_next;
    logic [15:0]                       rd_data_reg;
    logic                              rd_valid_reg;

    logic [JW-1:0] j_reg, j_next;
    logic          s2_valid_reg, s2_pal_reg, s2_last_reg;
    logic [15:0]   s2_direct_reg;

    logic          pix_item, pal_we, room, issue, last_pix, is_pal;
    logic [EW-1:0] step;
    logic [4:0]    pos, bpp, base, shamt;
    logic [31:0]   shifted;
    logic [7:0]    mask;
    logic [IW-1:0] rd_idx;
    logic [15:0]   half, direct;
    logic [15:0]   src;
    logic [5:0]    r6, g6, b6;
    logic [7:0]    r8, g8, b8;

    function automatic logic [15:0] widen1555(input logic [15:0] w);
        return {w[14:10], w[9:5], w[15], w[4:0]};
    endfunction

    function automatic logic [15:0] pack565(input logic [31:0] w);
        return {w[23:19], w[15:10], w[7:3]};
    endfunction

    function automatic logic [15:0] pack444(input logic [15:0] h);
        return {h[11:8], 1'b0, h[7:4], 2'b00, h[3:0], 1'b0};
    endfunction

    // ---- issue stage: one pixel per cycle from the queue head while the result queue has room
    assign pix_item = !wq_empty && !head.pal_write;
    assign pal_we   = !wq_empty && head.pal_write;
    assign room     = ((lpuc_pkg::RES_LVL_W + 1)'(res_level) + (lpuc_pkg::RES_LVL_W + 1)'(s2_valid_reg))
                      < (lpuc_pkg::RES_LVL_W + 1)'(lpuc_pkg::RES_DEPTH);
    assign issue    = pix_item && room;
    assign last_pix = ({1'b0, j_reg} == head.n_emit - 1'b1);
    assign wq_pop   = pal_we || (issue && last_pix);
    assign j_next   = issue ? (last_pix ? '0 : j_reg + 1'b1) : j_reg;
    assign is_pal   = cfg.pixel_mode inside {lpuc_pkg::MODE_PAL1, lpuc_pkg::MODE_PAL2,
                                             lpuc_pkg::MODE_PAL4, lpuc_pkg::MODE_PAL8};

    // palette index: bit position of pixel j within the word
    always_comb
    begin
        step    = ({1'b0, j_reg} + 1'b1) << cfg.pixel_mode[1:0];
        pos     = 5'(6'd32 - step);
        bpp     = 5'd1 << cfg.pixel_mode[1:0];
        base    = (cfg.byte_endian ? 5'd0 : 5'd24) ^ (cfg.pixel_endian ? 5'd0 : 5'd8 - bpp);
        shamt   = pos ^ base;
        shifted = head.word >> shamt;
        case (cfg.pixel_mode)
            lpuc_pkg::MODE_PAL1: mask = 8'h01;
            lpuc_pkg::MODE_PAL2: mask = 8'h03;
            lpuc_pkg::MODE_PAL4: mask = 8'h0F;
            default:             mask = 8'hFF;
        endcase
        rd_idx = pal_we ? head.pidx : (shifted[IW-1:0] & mask);
    end

    // direct-colour pixel in 565 layout
    always_comb
    begin
        half = (j_reg[0] ^ cfg.byte_endian) ? head.word[31:16] : head.word[15:0];
        case (cfg.pixel_mode)
            lpuc_pkg::MODE_1555: direct = widen1555(half);
            lpuc_pkg::MODE_888:  direct = pack565(head.word);
            lpuc_pkg::MODE_565:  direct = half;
            lpuc_pkg::MODE_444:  direct = pack444(half);
            default:             direct = '0;
        endcase
    end

    always_comb
    begin
        pal_valid_next = pal_valid_reg;
        if (pal_we)
        begin
            pal_valid_next[head.pidx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[head.pidx] <= head.word[15:0];
        end
        rd_data_reg   <= pal_mem[rd_idx];
        s2_pal_reg    <= is_pal;
        s2_last_reg   <= last_pix;
        s2_direct_reg <= direct;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            j_reg         <= '0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            pal_valid_reg <= pal_valid_next;
            rd_valid_reg  <= pal_valid_reg[rd_idx];
            j_reg         <= j_next;
            s2_valid_reg  <= issue;
        end
    end

    // ---- colour stage: expand to 888 and push the result
    always_comb
    begin
        src = s2_pal_reg ? widen1555(rd_valid_reg ? rd_data_reg : 16'h0000) : s2_direct_reg;
        r6  = {src[15:11], src[15]};
        g6  = src[10:5];
        b6  = {src[4:0], src[4]};
        r8  = {r6, r6[5:4]};
        g8  = {g6, g6[5:4]};
        b8  = {b6, b6[5:4]};
        res_data.first_byte   = cfg.rgb_order ? r8 : b8;
        res_data.middle_byte  = g8;
        res_data.third_byte   = cfg.rgb_order ? b8 : r8;
        res_data.last_of_word = s2_last_reg;
    end

    assign res_push = s2_valid_reg;

    `LPUC_NEVER(a_res_overrun, s2_valid_reg && (res_level == lpuc_pkg::RES_LVL_W'(lpuc_pkg::RES_DEPTH)), "result queue overrun")
    `LPUC_ASSERT(a_idle_index, (wq_empty || head.pal_write) |-> (j_reg == '0), "pixel index not at zero between words")
    `LPUC_ASSERT(a_index_range, pix_item |-> ({1'b0, j_reg} < head.n_emit), "pixel index past emit count")
    `LPUC_ASSERT(a_last_retires, (s2_valid_reg && s2_last_reg) |-> $past(wq_pop), "last pixel without word retire")

endmodule

[sv/lcd_pixel_unpack_convert_unit.sv]
// LCD pixel unpacker: takes framebuffer words and palette writes through a
// push/full queue port and returns RGB888 pixels through an empty/pop queue
// port, one item per pixel, last_of_word set on the final pixel of a word.
// Rate: an item is accepted every cycle while the two-entry work queue has
// room; the back end emits one pixel per cycle while the result queue has
// room. A framebuffer word yields up to 32/16/8/4 pixels in palette modes,
// 2 in modes 1555/565/444 and 1 in mode 888; a palette write yields none.
// The single-pixel-per-cycle issue loop in the back end sets the pace.
// A word accepted into an empty block reaches the result port through the
// palette read register, then the result queue. The 256-entry palette
// carries one valid bit per entry, cleared at reset; unwritten entries read
// as black, and no clearing pass is needed. Words that fall entirely past
// the frame size give no result. The user must write configuration only
// while idle; the block itself does not enforce this.

`include "lcd_pixel_unpack_convert_unit_assert.svh"

module lcd_pixel_unpack_convert_unit #(
    parameter int COUNT_BITS = lpuc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input queue side
    input  logic                              push,
    input  lpuc_pkg::in_item_t                in_item,
    output logic                              full,
    // result queue side
    output logic                              empty,
    input  logic                              pop,
    output lpuc_pkg::out_item_t               out_item,
    // register writes
    input  logic                              cfg_write,
    input  logic [lpuc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpuc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int WORK_W = $bits(lpuc_pkg::work_t);
    localparam int RES_W  = $bits(lpuc_pkg::out_item_t);

    lpuc_pkg::cfg_t      cfg_reg, cfg_next;
    lpuc_pkg::work_t     wq_in, wq_head;
    lpuc_pkg::out_item_t res_data;
    logic                wq_push, wq_pop, wq_full, wq_empty;
    logic                res_push, res_full;
    logic [$clog2(lpuc_pkg::WORK_DEPTH+1)-1:0] wq_level;
    logic [lpuc_pkg::RES_LVL_W-1:0]            res_level;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lpuc_pkg::REG_PIXEL_MODE:   cfg_next.pixel_mode   = cfg_data[2:0];
                lpuc_pkg::REG_RGB_ORDER:    cfg_next.rgb_order    = cfg_data[0];
                lpuc_pkg::REG_BYTE_ENDIAN:  cfg_next.byte_endian  = cfg_data[0];
                lpuc_pkg::REG_PIXEL_ENDIAN: cfg_next.pixel_endian = cfg_data[0];
                lpuc_pkg::REG_FRAME_PIXELS: cfg_next.frame_pixels = cfg_data[lpuc_pkg::FRAME_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, count pixels against the frame, classify
    lpuc_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .wq_full (wq_full),
        .wq_push (wq_push),
        .wq_data (wq_in)
    );

    assign full = wq_full;

    // work queue between front and back
    lpuc_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (lpuc_pkg::WORK_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (wq_push),
        .wr_data (wq_in),
        .pop     (wq_pop),
        .rd_data (wq_head),
        .full    (wq_full),
        .empty   (wq_empty),
        .level   (wq_level)
    );

    // back: palette lookup, unpack, colour expansion
    lpuc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .wq_empty  (wq_empty),
        .head      (wq_head),
        .wq_pop    (wq_pop),
        .res_level (res_level),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // result queue; back end never pushes without room
    lpuc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (lpuc_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .pop     (pop),
        .rd_data (out_item),
        .full    (res_full),
        .empty   (empty),
        .level   (res_level)
    );

    `LPUC_NEVER(a_work_overrun, wq_push && wq_full, "work queue overrun")
    `LPUC_NEVER(a_res_full_push, res_push && res_full, "push into full result queue")
    `LPUC_ASSERT(a_work_level, wq_empty |-> (wq_level == '0), "work queue level out of step")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Bench for the LCD pixel unpacker.
// Stimulus: a short scripted sequence (register writes and items), then
// randomized phases, each with its own register setting and a run of
// framebuffer words and palette writes.
// Checking: a shadow model of the unpacker (palette, frame counter,
// registers) expands every accepted item into the pixels it should yield;
// the pixels are queued and compared in order against what the block pops.
module testbench;

    import lpuc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 380;
    // Cycles allowed after the last pixel so that words which yield no pixel
    // (and palette writes) leave the work queue before a register write.
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 20;
    // Cycles with no handshake of any kind before the run is declared hung.
    // Longest legal quiet stretch is a receiver stall run or a settle wait.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CNT_W          = COUNT_BITS_DEF;

    // input item kinds
    localparam logic FUNC_WORD    = 1'b0;
    localparam logic FUNC_PALETTE = 1'b1;

    typedef enum logic { STEP_REG, STEP_ITEM } step_kind_t;

    // One line of the scripted sequence. golden_n < 0: pixels come from the
    // shadow model; otherwise golden_n copies of golden are expected.
    typedef struct {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t              item;
        int                    golden_n;
        out_item_t             golden;
    } step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    in_item_t              in_item;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    out_item_t             out_item;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lcd_pixel_unpack_convert_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow model: registers, palette and frame pixel counter
    // ------------------------------------------------------------------
    logic [2:0]         cfg_mode;
    logic               cfg_red_first;
    logic               cfg_byte_be;
    logic               cfg_pixel_be;
    logic [FRAME_W-1:0] cfg_frame_pixels;
    logic [15:0]        shadow_palette [PALETTE_DEPTH];
    logic [CNT_W-1:0]   frame_count;

    out_item_t word_pixels[$];     // pixels of the item just accepted
    out_item_t pending_pixels[$];  // pixels accepted in, not yet popped

    int  mismatches = 0;
    int  burst_left = 0;
    bit  dirty = 1'b0;             // items sent since the last register write
    int  quiet_cycles = 0;

    // 1555 -> 16-bit working colour: red in [15:11], 6-bit green in [10:5]
    // with the intensity bit as its LSB, blue in [4:0].
    function automatic logic [15:0] expand_1555(input logic [15:0] w);
        return {w[14:10], w[9:5], w[15], w[4:0]};
    endfunction

    // Working colour -> output pixel. 5-bit channels grow to 6 bits by
    // repeating their MSB, then every channel to 8 bits by repeating its
    // top two bits.
    function automatic out_item_t to_rgb888(input logic [15:0] x);
        logic [5:0] r6, g6, b6;
        logic [7:0] r8, g8, b8;
        out_item_t  p;
        r6 = {x[15:11], x[15]};
        g6 = x[10:5];
        b6 = {x[4:0], x[4]};
        r8 = {r6, r6[5:4]};
        g8 = {g6, g6[5:4]};
        b8 = {b6, b6[5:4]};
        p.first_byte   = cfg_red_first ? r8 : b8;
        p.middle_byte  = g8;
        p.third_byte   = cfg_red_first ? b8 : r8;
        p.last_of_word = 1'b0;
        return p;
    endfunction

    // Fills word_pixels with what one accepted item yields.
    task automatic unpack_item(input in_item_t it);
        logic [15:0] colors[$];
        logic [31:0] w;
        logic [31:0] mask;
        logic [31:0] field;
        logic [15:0] half;
        out_item_t   p;
        int          bpp, base, pos, k;
        word_pixels.delete();
        if (it.frame_start)
            frame_count = '0;
        if (it.func == FUNC_PALETTE)
        begin
            shadow_palette[it.palette_index] = it.data_word[15:0];
            return;
        end
        w = it.data_word;
        if (cfg_mode <= MODE_PAL8)
        begin
            // Indices walked from the high end of the word; the byte base and
            // the in-byte flip pick where each index actually sits.
            bpp  = 1 << cfg_mode;
            mask = (32'd1 << bpp) - 1;
            base = cfg_byte_be ? 0 : 24;
            if (!cfg_pixel_be)
                base = base ^ (8 - bpp);
            for (pos = 32 - bpp; pos >= 0; pos = pos - bpp)
            begin
                field = (w >> ((pos ^ base) & 31)) & mask;
                colors.push_back(expand_1555(shadow_palette[field[7:0]]));
            end
        end
        else if (cfg_mode == MODE_888)
        begin
            // 888 is cut to 565; byte order has no effect here
            colors.push_back({w[23:19], w[15:10], w[7:3]});
        end
        else
        begin
            if (cfg_byte_be)
                w = {w[15:0], w[31:16]};
            for (k = 0; k < 2; k++)
            begin
                half = k ? w[31:16] : w[15:0];
                case (cfg_mode)
                    MODE_1555: colors.push_back(expand_1555(half));
                    MODE_565:  colors.push_back(half);
                    default:   colors.push_back({half[11:8], 1'b0, half[7:4], 2'b00,
                                                 half[3:0], 1'b0});
                endcase
            end
        end
        // Frame limit and counter ceiling both stop emission mid-word.
        for (k = 0; k < colors.size() && frame_count < cfg_frame_pixels
                    && frame_count != {CNT_W{1'b1}}; k++)
        begin
            word_pixels.push_back(to_rgb888(colors[k]));
            frame_count = frame_count + 1'b1;
        end
        if (word_pixels.size() > 0)
        begin
            p = word_pixels.pop_back();
            p.last_of_word = 1'b1;
            word_pixels.push_back(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Drop push and wait until every expected pixel is out, then give
    // pixel-less items time to drain from the work queue.
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        if (dirty)
        begin
            settle();
            dirty = 1'b0;
        end
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PIXEL_MODE:   cfg_mode         = val[2:0];
            REG_RGB_ORDER:    cfg_red_first    = val[0];
            REG_BYTE_ENDIAN:  cfg_byte_be      = val[0];
            REG_PIXEL_ENDIAN: cfg_pixel_be     = val[0];
            REG_FRAME_PIXELS: cfg_frame_pixels = val[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    // Sender works in bursts: a random run of back-to-back items, then a
    // random gap (sometimes none).
    task automatic send_item(input in_item_t it, input int golden_n,
                             input out_item_t golden);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            repeat (gap)
            begin
                @(negedge clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        dirty = 1'b1;
        unpack_item(it);
        if (golden_n >= 0)
        begin
            word_pixels.delete();
            repeat (golden_n) word_pixels.push_back(golden);
        end
        foreach (word_pixels[k])
            pending_pixels.push_back(word_pixels[k]);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall style is redrawn whenever its timer runs out - never stall,
    // light random stalls, heavy random stalls, or a fixed 5-of-8 pattern.
    // ------------------------------------------------------------------
    int       stall_style = 0;
    int       stall_timer = 0;
    bit [2:0] stall_phase = '0;

    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_style <= $urandom_range(0, 3);
            stall_timer <= 40 + $urandom_range(0, 60);
        end
        else
        begin
            stall_timer <= stall_timer - 1;
        end
        stall_phase <= stall_phase + 1'b1;
        case (stall_style)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 9) < 7);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (stall_phase < 3'd5);
        endcase
    end

    // ------------------------------------------------------------------
    // Result check: every popped pixel against the oldest expected one
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %h %h %h last %b, got %h %h %h last %b",
                     $realtime, what, want.first_byte, want.middle_byte,
                     want.third_byte, want.last_of_word, got.first_byte,
                     got.middle_byte, got.third_byte, got.last_of_word);
    endtask

    always @(posedge clk)
    begin : check_pixels
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                note_mismatch("unexpected pixel", '0, out_item);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_item.first_byte   !== want.first_byte  ||
                    out_item.middle_byte  !== want.middle_byte ||
                    out_item.third_byte   !== want.third_byte  ||
                    out_item.last_of_word !== want.last_of_word)
                    note_mismatch("pixel mismatch", want, out_item);
            end
        end
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || cfg_write)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
                         WATCHDOG_LIMIT, pending_pixels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scripted sequence helpers
    // ------------------------------------------------------------------
    function automatic step_t reg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        step_t s;
        s.kind     = STEP_REG;
        s.reg_idx  = idx;
        s.reg_val  = val;
        s.item     = '0;
        s.golden_n = -1;
        s.golden   = '0;
        return s;
    endfunction

    function automatic step_t item_step(input logic func, input logic [31:0] word,
                                        input logic [7:0] pidx, input logic fs,
                                        input int golden_n, input out_item_t golden);
        step_t s;
        s.kind                = STEP_ITEM;
        s.reg_idx             = '0;
        s.reg_val             = '0;
        s.item.func           = func;
        s.item.data_word      = word;
        s.item.palette_index  = pidx;
        s.item.frame_start    = fs;
        s.golden_n            = golden_n;
        s.golden              = golden;
        return s;
    endfunction

    // single pixel that closes its word
    function automatic out_item_t lone_pixel(input logic [7:0] f, input logic [7:0] m,
                                             input logic [7:0] t);
        out_item_t p;
        p.first_byte   = f;
        p.middle_byte  = m;
        p.third_byte   = t;
        p.last_of_word = 1'b1;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    step_t script[$];

    initial
    begin
        in_item_t           it;
        logic [FRAME_W-1:0] fp;
        int                 random_sent;
        int                 phase_items;
        int                 pick;
        bit                 small_frame;

        rst_n     = 1'b0;
        push      = 1'b0;
        in_item   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // shadow state as after reset
        cfg_mode         = MODE_PAL1;
        cfg_red_first    = 1'b0;
        cfg_byte_be      = 1'b0;
        cfg_pixel_be     = 1'b0;
        cfg_frame_pixels = '0;
        frame_count      = '0;
        foreach (shadow_palette[i])
            shadow_palette[i] = 16'h0000;

        // Reset state: frame size zero, so the first word yields nothing.
        script.push_back(item_step(FUNC_WORD, 32'hFFFF_FFFF, 8'h00, 1'b0, 0, '0));
        script.push_back(reg_step(REG_FRAME_PIXELS, 20'hF_FFFF));
        // Palette writes give no pixel; frame start on one still clears count.
        script.push_back(item_step(FUNC_PALETTE, 32'hFFFF_FFFF, 8'hFF, 1'b1, 0, '0));
        script.push_back(item_step(FUNC_PALETTE, 32'hA5A5_7C1F, 8'h01, 1'b0, 0, '0));
        // 1 bpp, little endian both ways
        script.push_back(item_step(FUNC_WORD, 32'h8000_0001, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_PAL2)));
        script.push_back(reg_step(REG_BYTE_ENDIAN, CFG_DATA_W'(1)));
        script.push_back(item_step(FUNC_WORD, 32'h1B1B_E4E4, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_PIXEL_ENDIAN, CFG_DATA_W'(1)));
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_PAL4)));
        script.push_back(item_step(FUNC_WORD, 32'h0123_4567, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_BYTE_ENDIAN, CFG_DATA_W'(0)));
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_PAL8)));
        script.push_back(item_step(FUNC_WORD, 32'hFF01_00FF, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_PIXEL_ENDIAN, CFG_DATA_W'(0)));
        script.push_back(item_step(FUNC_WORD, 32'h00FF_01FF, 8'h00, 1'b0, -1, '0));
        // 888: white, black (top byte ignored), pure red in both orders
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_888)));
        script.push_back(item_step(FUNC_WORD, 32'h00FF_FFFF, 8'h00, 1'b0, 1,
                                   lone_pixel(8'hFF, 8'hFF, 8'hFF)));
        script.push_back(item_step(FUNC_WORD, 32'hFF00_0000, 8'h00, 1'b0, 1,
                                   lone_pixel(8'h00, 8'h00, 8'h00)));
        script.push_back(item_step(FUNC_WORD, 32'h00FF_0000, 8'h00, 1'b0, 1,
                                   lone_pixel(8'h00, 8'h00, 8'hFF)));
        script.push_back(reg_step(REG_RGB_ORDER, CFG_DATA_W'(1)));
        script.push_back(item_step(FUNC_WORD, 32'h00FF_0000, 8'h00, 1'b0, 1,
                                   lone_pixel(8'hFF, 8'h00, 8'h00)));
        // big-endian bytes do not swap anything in 888 mode
        script.push_back(reg_step(REG_BYTE_ENDIAN, CFG_DATA_W'(1)));
        script.push_back(item_step(FUNC_WORD, 32'h0000_00FF, 8'h00, 1'b0, 1,
                                   lone_pixel(8'h00, 8'h00, 8'hFF)));
        // 16-bit modes with halfword swap
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_1555)));
        script.push_back(item_step(FUNC_WORD, 32'h8000_7FFF, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_565)));
        script.push_back(item_step(FUNC_WORD, 32'hF800_001F, 8'h00, 1'b0, -1, '0));
        script.push_back(reg_step(REG_PIXEL_MODE, CFG_DATA_W'(MODE_444)));
        script.push_back(item_step(FUNC_WORD, 32'h0FFF_0F00, 8'h00, 1'b0, -1, '0));
        // Frame of three pixels: full word, cut word, then nothing.
        script.push_back(reg_step(REG_BYTE_ENDIAN, CFG_DATA_W'(0)));
        script.push_back(reg_step(REG_FRAME_PIXELS, CFG_DATA_W'(3)));
        script.push_back(item_step(FUNC_WORD, 32'h0ABC_0123, 8'h00, 1'b1, -1, '0));
        script.push_back(item_step(FUNC_WORD, 32'h0FFF_0000, 8'h00, 1'b0, -1, '0));
        script.push_back(item_step(FUNC_WORD, 32'h0FFF_0FFF, 8'h00, 1'b0, 0, '0));
        // frame start carried by a palette write reopens the frame
        script.push_back(item_step(FUNC_PALETTE, 32'h5A5A_8421, 8'h80, 1'b1, 0, '0));
        script.push_back(item_step(FUNC_WORD, 32'h0000_0000, 8'h00, 1'b0, -1, '0));
        // zero frame size drops everything, even right after a frame start
        script.push_back(reg_step(REG_FRAME_PIXELS, CFG_DATA_W'(0)));
        script.push_back(item_step(FUNC_WORD, 32'h1234_5678, 8'h00, 1'b1, 0, '0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == STEP_REG)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                send_item(script[i].item, script[i].golden_n, script[i].golden);
        end

        // Random phases: new register setting, then a run of mixed items.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                fp = '0;
            else if (pick <= 3)
                fp = FRAME_W'($urandom_range(1, 40));
            else if (pick == 4)
                fp = 20'hF_FFFF;
            else
                fp = FRAME_W'($urandom_range(41, 20'hF_FFFF));
            // short frames get frequent frame starts so words keep flowing
            small_frame = (fp <= 40);

            write_reg(REG_PIXEL_MODE,   CFG_DATA_W'($urandom_range(0, 7)));
            write_reg(REG_RGB_ORDER,    CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_BYTE_ENDIAN,  CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_PIXEL_ENDIAN, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(REG_FRAME_PIXELS, fp);

            phase_items = $urandom_range(8, 36);
            repeat (phase_items)
            begin
                it.func      = ($urandom_range(0, 3) == 0) ? FUNC_PALETTE : FUNC_WORD;
                it.data_word = $urandom;
                if ($urandom_range(0, 7) == 0)
                    it.data_word = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                it.palette_index = 8'($urandom_range(0, 255));
                it.frame_start   = small_frame ? ($urandom_range(0, 3) == 0)
                                               : ($urandom_range(0, 15) == 0);
                send_item(it, -1, '0);
                random_sent++;
            end
        end

        // Drain, then leave room for any stray pixel to show up.
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/lpuc_pkg.sv
sv/lpuc_fifo.sv
sv/lpuc_front.sv
sv/lpuc_back.sv
sv/lcd_pixel_unpack_convert_unit.sv
bench/testbench.sv
